// File: rtl/bfha_pkg.sv
// shared constants of the best-fit heap allocator
`default_nettype none
package bfha_pkg;
	localparam int HEAP_BYTES_DEF     = 4096;
	localparam int BLOCK_OVERHEAD_DEF = 16;
	localparam int USER_OFFSET_DEF    = 12;

	localparam int SIZE_W = 13;   // request_size and heap_size fields
	localparam int ADDR_W = 12;   // block_address and result_address fields

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
endpackage
`default_nettype wire

// File: rtl/bfha_ram.sv
// generic single write port ram with registered read
`default_nettype none
module bfha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/best_fit_heap_allocator.sv
// best-fit heap allocator with boundary tags, top level
`default_nettype none
// Manages a heap of heap_size bytes (at most HEAP_BYTES). Every block carries
// BLOCK_OVERHEAD bytes: a signed size tag at its start (start tag memory), a
// free-list link (link memory) and a copy of the tag at its end (end tag
// memory); a positive tag means free, a negative one allocated. Each request
// on the req channel gives exactly one transfer on the rsp channel, unless a
// heap_size write restarts the heap while it is in work. An allocate walks
// the whole free list, reading each free block and then comparing its tag,
// and writes the tags and links in A_W1, A_W2 (only on a split) and A_W3. A
// free walks the block chain from offset zero up to the freed one, reads the
// left and right neighbors and, when the right neighbor is free, walks the
// free list again to unlink it. Latency therefore depends on the list and
// chain lengths. One item is in work at a time; the result register lets
// the next request in while the previous answer waits. After reset or a
// heap_size write the block writes the initial tags in S_INIT before taking
// requests.
module best_fit_heap_allocator
	import bfha_pkg::*;
#(
	parameter int HEAP_BYTES     = HEAP_BYTES_DEF,
	parameter int BLOCK_OVERHEAD = BLOCK_OVERHEAD_DEF,
	parameter int USER_OFFSET    = USER_OFFSET_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              heap_size_we,
	input  wire logic [SIZE_W-1:0] heap_size,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              action,
	input  wire logic [SIZE_W-1:0] request_size,
	input  wire logic [ADDR_W-1:0] block_address,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [ADDR_W-1:0] result_address,
	output logic                   success
);
	localparam int AW = $clog2(HEAP_BYTES);      // memory address
	localparam int LW = $clog2(HEAP_BYTES + 1);  // offsets and links, nil included
	localparam int TW = LW + 1;                  // signed size tags
	localparam logic [LW-1:0] NIL = LW'(HEAP_BYTES);

	localparam logic [4:0] S_INIT = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_DONE = 5'd2;
	localparam logic [4:0] A_RD   = 5'd3;
	localparam logic [4:0] A_EV   = 5'd4;
	localparam logic [4:0] A_END  = 5'd5;
	localparam logic [4:0] A_W1   = 5'd6;
	localparam logic [4:0] A_W2   = 5'd7;
	localparam logic [4:0] A_W3   = 5'd8;
	localparam logic [4:0] F_RD   = 5'd9;
	localparam logic [4:0] F_EV   = 5'd10;
	localparam logic [4:0] F_ERD  = 5'd11;
	localparam logic [4:0] F_EEV  = 5'd12;
	localparam logic [4:0] F_LRD  = 5'd13;
	localparam logic [4:0] F_LEV  = 5'd14;
	localparam logic [4:0] F_RRD  = 5'd15;
	localparam logic [4:0] F_REV  = 5'd16;
	localparam logic [4:0] F_WRD  = 5'd17;
	localparam logic [4:0] F_WEV  = 5'd18;
	localparam logic [4:0] F_FIX  = 5'd19;

	function automatic logic [TW-1:0] pos_tag(input logic [LW-1:0] v);
		pos_tag = {1'b0, v};
	endfunction

	function automatic logic [TW-1:0] neg_tag(input logic [LW-1:0] v);
		neg_tag = -{1'b0, v};
	endfunction

	function automatic logic [AW-1:0] ma(input logic [LW-1:0] v);
		ma = v[AW-1:0];
	endfunction

	// control and heap registers
	logic [4:0]    state_q;
	logic [LW-1:0] size_q;
	logic          live_q;
	logic [LW-1:0] head_q;

	// walk registers
	logic [LW-1:0] it_q, prev_q, best_q, bprev_q, blink_q, need_q;
	logic signed [TW-1:0] btag_q;
	logic [LW-1:0] d_q, pos_q, left_q, right_q, sz_q, cur_q, rt_q, rlink_q, rprev_q;
	logic          merged_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic          res_ok_q;

	// output register
	logic          rsp_valid_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic          rsp_ok_q;

	// memory ports
	logic [AW-1:0] rd_addr;
	logic          st_we, en_we, lk_we;
	logic [AW-1:0] st_wa, en_wa, lk_wa;
	logic [TW-1:0] st_wd, en_wd, st_rdata, en_rdata;
	logic [LW-1:0] lk_wd, lk_rd;

	logic signed [TW-1:0] st_rd, en_rd;
	logic [LW-1:0] t_mag, e_mag, alloc_len, rest, rem, cur_new, tot;
	logic          split, fits;
	logic [LW:0]   pos_next;

	assign st_rd = $signed(st_rdata);
	assign en_rd = $signed(en_rdata);
	assign t_mag = st_rd[TW-1] ? LW'(-st_rd) : LW'(st_rd);
	assign e_mag = en_rd[TW-1] ? LW'(-en_rd) : LW'(en_rd);

	// best-fit candidate test on the tag just read
	assign fits = (int'(st_rd) >= int'(need_q)) && ((best_q == NIL) || (st_rd < btag_q));
	// split when more than one overhead is left
	assign split     = int'(btag_q) > int'(need_q) + BLOCK_OVERHEAD;
	assign alloc_len = split ? need_q : LW'(btag_q);
	assign rest      = best_q + need_q;
	assign rem       = LW'(btag_q) - need_q;
	assign cur_new   = LW'(st_rd) + sz_q;
	assign tot       = cur_q + rt_q;
	assign pos_next  = {1'b0, pos_q} + {1'b0, t_mag};

	assign req_stall      = (state_q != S_IDLE) || heap_size_we;
	assign rsp_valid      = rsp_valid_q;
	assign result_address = rsp_addr_q;
	assign success        = rsp_ok_q;

	bfha_ram #(.WIDTH(TW), .DEPTH(HEAP_BYTES)) u_start_ram (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(rd_addr), .rdata(st_rdata)
	);

	bfha_ram #(.WIDTH(TW), .DEPTH(HEAP_BYTES)) u_end_ram (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd),
		.raddr(rd_addr), .rdata(en_rdata)
	);

	bfha_ram #(.WIDTH(LW), .DEPTH(HEAP_BYTES)) u_link_ram (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
		.raddr(rd_addr), .rdata(lk_rd)
	);

	// read address and write ports per state
	always_comb begin
		rd_addr = '0;
		st_we = 1'b0; st_wa = '0; st_wd = '0;
		en_we = 1'b0; en_wa = '0; en_wd = '0;
		lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
		unique case (state_q)
			S_INIT: begin
				// whole heap as one free block
				st_we = live_q; st_wa = '0;                  st_wd = pos_tag(size_q);
				en_we = live_q; en_wa = ma(size_q - 1'b1);   en_wd = pos_tag(size_q);
				lk_we = live_q; lk_wa = '0;                  lk_wd = NIL;
			end
			A_RD:  rd_addr = ma(it_q);
			A_W1: begin
				st_we = 1'b1; st_wa = ma(best_q); st_wd = neg_tag(alloc_len);
				en_we = 1'b1; en_wa = ma(best_q + alloc_len - 1'b1);
				en_wd = neg_tag(alloc_len);
				lk_we = 1'b1; lk_wa = ma(best_q); lk_wd = NIL;
			end
			A_W2: begin
				// leftover becomes a free block in the same list place
				st_we = 1'b1; st_wa = ma(rest); st_wd = pos_tag(rem);
				en_we = 1'b1; en_wa = ma(best_q + LW'(btag_q) - 1'b1);
				en_wd = pos_tag(rem);
				lk_we = 1'b1; lk_wa = ma(rest); lk_wd = blink_q;
			end
			A_W3: begin
				lk_we = (bprev_q != NIL); lk_wa = ma(bprev_q);
				lk_wd = split ? rest : blink_q;
			end
			F_RD:  rd_addr = ma(pos_q);
			F_EV: begin
				// mark the block free as soon as it is found
				if (pos_q == d_q && st_rd != '0 && st_rd[TW-1]) begin
					st_we = 1'b1; st_wa = ma(d_q); st_wd = pos_tag(t_mag);
					en_we = 1'b1; en_wa = ma(d_q + t_mag - 1'b1); en_wd = pos_tag(t_mag);
				end
			end
			F_ERD: rd_addr = ma(d_q - 1'b1);
			F_LRD: rd_addr = ma(left_q);
			F_LEV: begin
				if (left_q < d_q && st_rd > 0) begin
					st_we = 1'b1; st_wa = ma(left_q);          st_wd = pos_tag(cur_new);
					en_we = 1'b1; en_wa = ma(right_q - 1'b1);  en_wd = pos_tag(cur_new);
				end
			end
			F_RRD: rd_addr = ma(right_q);
			F_REV: begin
				lk_we = !merged_q; lk_wa = ma(d_q); lk_wd = head_q;
			end
			F_WRD: rd_addr = ma(it_q);
			F_FIX: begin
				lk_we = (rprev_q != right_q); lk_wa = ma(rprev_q); lk_wd = rlink_q;
				st_we = 1'b1; st_wa = ma(d_q); st_wd = pos_tag(tot);
				en_we = 1'b1; en_wa = ma(right_q + rt_q - 1'b1); en_wd = pos_tag(tot);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			size_q      <= LW'(HEAP_BYTES);
			live_q      <= 1'b1;
			head_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the done state reloads the output register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (heap_size_we) begin
				// heap_size write restarts the heap, clamped to the memory size
				if (int'(heap_size) > HEAP_BYTES) begin
					size_q <= LW'(HEAP_BYTES);
					live_q <= HEAP_BYTES > BLOCK_OVERHEAD;
					head_q <= (HEAP_BYTES > BLOCK_OVERHEAD) ? '0 : NIL;
				end else begin
					size_q <= LW'(heap_size);
					live_q <= int'(heap_size) > BLOCK_OVERHEAD;
					head_q <= (int'(heap_size) > BLOCK_OVERHEAD) ? '0 : NIL;
				end
				state_q <= S_INIT;
			end else begin
				unique case (state_q)
					S_INIT: state_q <= S_IDLE;
					S_IDLE: begin
						if (req_valid) begin
							res_addr_q <= '0;
							res_ok_q   <= 1'b0;
							if (action == ACT_ALLOC) begin
								it_q   <= head_q;
								prev_q <= NIL;
								best_q <= NIL;
								need_q <= LW'(int'(request_size) + BLOCK_OVERHEAD);
								if (live_q && request_size != '0 &&
								    int'(request_size) <= int'(size_q) - BLOCK_OVERHEAD) begin
									state_q <= A_RD;
								end else begin
									state_q <= S_DONE;
								end
							end else begin
								pos_q    <= '0;
								merged_q <= 1'b0;
								d_q      <= LW'(int'(block_address) - USER_OFFSET);
								if (live_q && int'(block_address) >= USER_OFFSET &&
								    int'(block_address) - USER_OFFSET < int'(size_q)) begin
									state_q <= F_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
						end
					end
					S_DONE: begin
						if (!rsp_valid_q || !rsp_stall) begin
							rsp_valid_q <= 1'b1;
							rsp_addr_q  <= res_addr_q;
							rsp_ok_q    <= res_ok_q;
							state_q     <= S_IDLE;
						end
					end
					// allocate: free list walk
					A_RD: state_q <= (it_q == NIL) ? A_END : A_EV;
					A_EV: begin
						if (fits) begin
							best_q  <= it_q;
							bprev_q <= prev_q;
							blink_q <= lk_rd;
							btag_q  <= st_rd;
						end
						prev_q  <= it_q;
						it_q    <= lk_rd;
						state_q <= A_RD;
					end
					A_END: state_q <= (best_q == NIL) ? S_DONE : A_W1;
					A_W1:  state_q <= split ? A_W2 : A_W3;
					A_W2:  state_q <= A_W3;
					A_W3: begin
						if (bprev_q == NIL) begin
							head_q <= split ? rest : blink_q;
						end
						res_addr_q <= ADDR_W'(int'(best_q) + USER_OFFSET);
						res_ok_q   <= 1'b1;
						state_q    <= S_DONE;
					end
					// free: chain walk from offset zero
					F_RD: state_q <= F_EV;
					F_EV: begin
						if (st_rd == '0) begin
							state_q <= S_DONE;
						end else if (pos_q == d_q) begin
							if (st_rd[TW-1]) begin
								sz_q    <= t_mag;
								cur_q   <= t_mag;
								right_q <= d_q + t_mag;
								state_q <= (d_q != '0) ? F_ERD : F_RRD;
							end else begin
								state_q <= S_DONE;
							end
						end else if (pos_next > {1'b0, d_q}) begin
							state_q <= S_DONE;
						end else begin
							pos_q   <= pos_next[LW-1:0];
							state_q <= F_RD;
						end
					end
					F_ERD: state_q <= F_EEV;
					F_EEV: begin
						left_q  <= d_q - e_mag;
						state_q <= F_LRD;
					end
					F_LRD: state_q <= F_LEV;
					F_LEV: begin
						// left neighbor free: it absorbs this block
						if (left_q < d_q && st_rd > 0) begin
							merged_q <= 1'b1;
							cur_q    <= cur_new;
							d_q      <= left_q;
						end
						state_q <= F_RRD;
					end
					F_RRD: state_q <= F_REV;
					F_REV: begin
						rt_q    <= LW'(st_rd);
						rlink_q <= lk_rd;
						if (!merged_q) begin
							head_q <= d_q;
						end
						if (right_q < size_q && st_rd > 0) begin
							it_q    <= merged_q ? head_q : d_q;
							rprev_q <= merged_q ? head_q : d_q;
							state_q <= (merged_q && head_q == NIL) ? F_FIX : F_WRD;
						end else begin
							res_ok_q <= 1'b1;
							state_q  <= S_DONE;
						end
					end
					// free: find the list entry in front of the right neighbor
					F_WRD: state_q <= F_WEV;
					F_WEV: begin
						if (lk_rd == right_q) begin
							rprev_q <= it_q;
							state_q <= F_FIX;
						end else if (lk_rd == NIL) begin
							state_q <= F_FIX;
						end else begin
							it_q    <= lk_rd;
							state_q <= F_WRD;
						end
					end
					F_FIX: begin
						if (rprev_q == right_q) begin
							head_q <= rlink_q;
						end
						res_ok_q <= 1'b1;
						state_q  <= S_DONE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule
`default_nettype wire
